@@ sv/ltsl_pkg.sv @@
package ltsl_pkg;

	// Strip geometry
	localparam int LED_COUNT  = 32;
	localparam int WARN_HALF  = 4;
	localparam int SHIFT_HALF = 2;
	localparam int LED_MID    = LED_COUNT / 2;

	// Field widths
	localparam int RPM_W  = 16;
	localparam int TIME_W = 32;
	localparam int IDX_W  = 6;
	localparam int COL_W  = 8;

	// Gap half-width holds 0..LED_MID; dividend holds (rpm span) * LED_MID
	localparam int GAP_W = $clog2(LED_MID + 1);
	localparam int NUM_W = RPM_W + GAP_W;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

	// Configuration register indexes
	localparam int CFG_W = 2;
	localparam logic [CFG_W-1:0] CFG_TACH_MIN     = 2'd0;
	localparam logic [CFG_W-1:0] CFG_TACH_MAX     = 2'd1;
	localparam logic [CFG_W-1:0] CFG_FLASH_PERIOD = 2'd2;

	// Reset values of the registers
	localparam logic [RPM_W-1:0] TACH_MIN_RST     = 16'd3000;
	localparam logic [RPM_W-1:0] TACH_MAX_RST     = 16'd6500;
	localparam logic [RPM_W-1:0] FLASH_PERIOD_RST = 16'd50;

	// Zone colors
	localparam logic [COL_W-1:0] NORM_R  = 8'd30;
	localparam logic [COL_W-1:0] NORM_G  = 8'd15;
	localparam logic [COL_W-1:0] WARN_R  = 8'd80;
	localparam logic [COL_W-1:0] WARN_G  = 8'd10;
	localparam logic [COL_W-1:0] SHIFT_R = 8'd80;
	localparam logic [COL_W-1:0] SHIFT_G = 8'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
	} rg_t;

	// Divider handshake
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [RPM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

	// Color of one LED; later zones override earlier ones
	function automatic rg_t led_color(input logic [IDX_W-1:0] idx,
			input logic [GAP_W-1:0] gap, input logic dark, input logic black);
		int  i;
		int  b;
		rg_t c;
		i = int'(idx);
		b = int'(gap);
		c = '0;
		if (i <= LED_MID - WARN_HALF || i >= LED_MID + WARN_HALF + 1) begin
			c.red   = NORM_R;
			c.green = NORM_G;
		end
		if ((i >= LED_MID - WARN_HALF - 1 && i <= LED_MID - SHIFT_HALF) ||
				(i >= LED_MID + SHIFT_HALF + 1 && i <= LED_MID + WARN_HALF)) begin
			c.red   = WARN_R;
			c.green = WARN_G;
		end
		if (i >= LED_MID - SHIFT_HALF - 1 && i <= LED_MID + SHIFT_HALF) begin
			c.red   = SHIFT_R;
			c.green = SHIFT_G;
		end
		if (i >= LED_MID - b && i <= LED_MID + b - 1) begin
			c = '0;
		end
		if (dark && i >= LED_MID - SHIFT_HALF - 1 && i <= LED_MID + SHIFT_HALF) begin
			c = '0;
		end
		if (black) begin
			c = '0;
		end
		return c;
	endfunction

endpackage

@@ sv/ltsl_div.sv @@
// Restoring divider, one quotient bit per cycle
module ltsl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ltsl_pkg::div_req_t  req,
	output ltsl_pkg::div_rsp_t  rsp
);

	logic [ltsl_pkg::RPM_W-1:0]  rem_q;
	logic [ltsl_pkg::NUM_W-1:0]  quo_q;
	logic [ltsl_pkg::RPM_W-1:0]  den_q;
	logic [ltsl_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ltsl_pkg::RPM_W:0]    trial;
	logic [ltsl_pkg::RPM_W:0]    diff;
	logic                        fits;

	// Shared subtract and compare
	assign trial = {rem_q, quo_q[ltsl_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= ltsl_pkg::DCNT_W'(ltsl_pkg::NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ltsl_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ltsl_pkg::RPM_W-1:0] : trial[ltsl_pkg::RPM_W-1:0];
			quo_q <= {quo_q[ltsl_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	as_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	as_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && $past(busy_q) && !$past(req.start) |-> rem_q < den_q)
		else $error("divider remainder not below divisor");
	as_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider restarted while busy");

endmodule

@@ sv/led_tach_shift_light.sv @@
// Channel  Dir  Width  Contents (low bit first)
// s_*      in   64     display_rpm[15:0], engine_rpm[31:16], now_ms[63:32]
// m_*      out  32     led_index[5:0], red[13:6], green[21:14], blue[29:22]; tlast=last_led
// cfg_*    in   16     write: 0 tach_min, 1 tach_max, 2 flash_period_ms
//
// One frame: accept, then the divide (21 quotient bits, one per cycle
// in the shared subtractor, then the gap is loaded), then 32 LED transactions.
// Below tach_min or with tach_max <= tach_min the divider is skipped.
// s_tready is high only while no frame is in progress; the last LED may still
// wait in the output register when the next frame is accepted.
// m_tready low stalls LED output; arst_n clears control and flash state.
module led_tach_shift_light (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // display_rpm, engine_rpm, now_ms
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // led_index, red, green, blue, pad
	output logic                          m_tlast,   // last_led
	input  logic                          cfg_we,
	input  logic [ltsl_pkg::CFG_W-1:0]    cfg_index,
	input  logic [ltsl_pkg::RPM_W-1:0]    cfg_data
);

	ltsl_pkg::state_t state_q, state_nx;

	logic [ltsl_pkg::RPM_W-1:0]  tach_min_q;
	logic [ltsl_pkg::RPM_W-1:0]  tach_max_q;
	logic [ltsl_pkg::RPM_W-1:0]  flash_period_q;
	logic [ltsl_pkg::TIME_W-1:0] flash_time_q;
	logic                        flash_phase_q;
	logic                        dark_q;
	logic                        black_q;
	logic [ltsl_pkg::GAP_W-1:0]  gap_q;
	logic [ltsl_pkg::IDX_W-1:0]  cnt_q;

	logic                        out_valid_q;
	logic [ltsl_pkg::IDX_W-1:0]  out_idx_q;
	ltsl_pkg::rg_t               out_col_q;
	logic                        out_last_q;

	logic [ltsl_pkg::RPM_W-1:0]  in_disp;
	logic [ltsl_pkg::RPM_W-1:0]  in_eng;
	logic [ltsl_pkg::TIME_W-1:0] in_now;
	logic                        accept;
	logic                        in_black;
	logic                        span_ok;
	logic                        skip_div;
	logic                        over_rev;
	logic                        toggle;
	logic                        load_out;
	logic [ltsl_pkg::TIME_W-1:0] elapsed;
	ltsl_pkg::div_req_t          div_req;
	ltsl_pkg::div_rsp_t          div_rsp;
	ltsl_pkg::rg_t               col;

	assign in_disp = s_tdata[15:0];
	assign in_eng  = s_tdata[31:16];
	assign in_now  = s_tdata[63:32];

	// Frame setup decisions
	assign accept   = s_tvalid && s_tready;
	assign in_black = in_disp < tach_min_q;
	assign span_ok  = tach_max_q > tach_min_q;
	assign skip_div = in_black || !span_ok;
	assign over_rev = !in_black && (in_eng > tach_max_q);
	assign elapsed  = in_now - flash_time_q;
	assign toggle   = over_rev && (elapsed > ltsl_pkg::TIME_W'(flash_period_q));

	// Divider request
	assign div_req.start    = accept && !skip_div;
	assign div_req.dividend = ltsl_pkg::NUM_W'(in_disp - tach_min_q) *
		ltsl_pkg::NUM_W'(ltsl_pkg::LED_MID);
	assign div_req.divisor  = tach_max_q - tach_min_q;

	ltsl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ltsl_pkg::ST_IDLE: begin
				if (accept) state_nx = skip_div ? ltsl_pkg::ST_EMIT : ltsl_pkg::ST_DIV;
			end
			ltsl_pkg::ST_DIV: begin
				if (div_rsp.done) state_nx = ltsl_pkg::ST_EMIT;
			end
			ltsl_pkg::ST_EMIT: begin
				if (load_out && cnt_q == ltsl_pkg::LAST_IDX) state_nx = ltsl_pkg::ST_IDLE;
			end
			default: state_nx = ltsl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ltsl_pkg::ST_IDLE: s_tready = 1'b1;
			ltsl_pkg::ST_DIV:  s_tready = 1'b0;
			ltsl_pkg::ST_EMIT: load_out = !out_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ltsl_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tach_min_q     <= ltsl_pkg::TACH_MIN_RST;
			tach_max_q     <= ltsl_pkg::TACH_MAX_RST;
			flash_period_q <= ltsl_pkg::FLASH_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ltsl_pkg::CFG_TACH_MIN:     tach_min_q     <= cfg_data;
				ltsl_pkg::CFG_TACH_MAX:     tach_max_q     <= cfg_data;
				ltsl_pkg::CFG_FLASH_PERIOD: flash_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flash state, stepped on an accepted frame when over-rev and the flash period has elapsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_time_q  <= '0;
			flash_phase_q <= 1'b0;
		end else if (accept && toggle) begin
			flash_time_q  <= in_now;
			flash_phase_q <= !flash_phase_q;
		end
	end

	// Frame attributes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= 1'b0;
			black_q <= 1'b0;
			gap_q   <= '0;
		end else if (accept) begin
			dark_q  <= over_rev && (flash_phase_q ^ toggle);
			black_q <= in_black;
			gap_q   <= '0;
		end else if (state_q == ltsl_pkg::ST_DIV && div_rsp.done) begin
			if (div_rsp.quotient < ltsl_pkg::NUM_W'(ltsl_pkg::LED_MID))
				gap_q <= ltsl_pkg::GAP_W'(ltsl_pkg::NUM_W'(ltsl_pkg::LED_MID) -
					div_rsp.quotient);
			else
				gap_q <= '0;
		end
	end

	// LED counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (accept) cnt_q <= '0;
		else if (load_out) cnt_q <= cnt_q + 1'b1;
	end

	assign col = ltsl_pkg::led_color(cnt_q, gap_q, dark_q, black_q);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= cnt_q;
			out_col_q  <= col;
			out_last_q <= cnt_q == ltsl_pkg::LAST_IDX;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, ltsl_pkg::COL_W'(0), out_col_q.green, out_col_q.red, out_idx_q};
	assign m_tlast  = out_last_q;

	as_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ltsl_pkg::ST_IDLE)
		else $error("frame accepted but sequencer stayed idle");
	as_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ltsl_pkg::ST_DIV)
		else $error("divider finished outside divide state");
	as_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[5:0] == ltsl_pkg::LAST_IDX)
		else $error("last LED flag on wrong index");
	as_gap_range: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q <= ltsl_pkg::GAP_W'(ltsl_pkg::LED_MID))
		else $error("gap wider than half the strip");

endmodule
